FILE: hw/rtl/nlfr_pkg.sv
`default_nettype none

package nlfr_pkg;

  localparam int unsigned TIMER_WIDTH_DEFAULT = 16;

  localparam int unsigned LINES_W    = 5;
  localparam int unsigned NIBBLE_W   = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LENGTH_W   = 16;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned RETRY_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 2'd2;

  localparam logic [TIMEOUT_W-1:0] NIBBLE_TIMEOUT_RESET = 16'd3000;
  localparam logic [LENGTH_W-1:0]  MAX_LENGTH_RESET     = 16'd1500;
  localparam logic [RETRY_W-1:0]   MAX_RETRIES_RESET    = 3'd2;

  localparam logic [LENGTH_W-1:0] MIN_LENGTH = 16'd8;

  // line patterns
  localparam logic [LINES_W-1:0] PAT_START    = 5'h18;
  localparam logic [LINES_W-1:0] PAT_RECOVER  = 5'h10;
  localparam logic [LINES_W-1:0] DRV_START    = 5'h01;
  localparam logic [LINES_W-1:0] DRV_LOW_ACK  = 5'h10;
  localparam logic [LINES_W-1:0] DRV_HIGH_ACK = 5'h00;
  localparam logic [LINES_W-1:0] DRV_IDLE     = 5'h00;
  localparam int unsigned STROBE_BIT = 4;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_GOOD     = 3'd1,
    EV_CHECKSUM = 3'd2,
    EV_LENGTH   = 3'd3,
    EV_TIMEOUT  = 3'd4
  } frame_event_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nlfr_status_if.sv
`default_nettype none

interface nlfr_status_if;
  import nlfr_pkg::*;

  logic               valid;
  logic               ready;
  logic [LINES_W-1:0] status_lines;

  modport source (output valid, output status_lines, input ready);
  modport sink   (input valid, input status_lines, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nlfr_result_if.sv
`default_nettype none

interface nlfr_result_if;
  import nlfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [LINES_W-1:0]  drive_lines;
  logic                byte_valid;
  logic [BYTE_W-1:0]   byte_value;
  logic                byte_last;
  frame_event_t        frame_event;
  logic [LENGTH_W-1:0] frame_length;
  logic                link_busy;

  modport source (
    output valid, output drive_lines, output byte_valid, output byte_value,
    output byte_last, output frame_event, output frame_length, output link_busy,
    input ready
  );
  modport sink (
    input valid, input drive_lines, input byte_valid, input byte_value,
    input byte_last, input frame_event, input frame_length, input link_busy,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/nibble_link_frame_receiver.sv
// nibble-mode parallel link, receive side
// status: one word per microsecond tick, the five status lines (bit 4 is
//   the strobe, bits 3..0 a nibble)
// result: one word per status word, with the value to drive on D4..D0,
//   any data byte completed this tick (with a last flag), a frame event
//   (good, checksum, bad length, timeout abort) with the length field,
//   and a busy flag
// cfg_we/cfg_index/cfg_data: nibble timeout, maximum length and maximum
//   retries; write only while no word is in flight
// latency: a result word appears on the cycle after its status word is
//   taken; one status word is taken every cycle unless a result stalls; the
//   per-tick update is one pass of logic between the state and result registers
// a stalled result holds in its register and status ready drops until it
//   is taken; data bytes are not buffered, so downstream discards a frame
//   on an error event
// reset (rst, synchronous) leaves the link idle waiting for the start
//   pattern, the registers at their defaults and no result pending
`default_nettype none

module nibble_link_frame_receiver #(
  parameter int unsigned TIMER_WIDTH = nlfr_pkg::TIMER_WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [nlfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nlfr_pkg::CFG_DATA_W-1:0] cfg_data,
  nlfr_status_if.sink                        status,
  nlfr_result_if.source                      result
);
  import nlfr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_DATA    = 3'd3,
    PH_SUM     = 3'd4,
    PH_RECOVER = 3'd5
  } phase_t;

  logic [TIMEOUT_W-1:0] nibble_timeout;
  logic [LENGTH_W-1:0]  max_length;
  logic [RETRY_W-1:0]   max_retries;

  phase_t                 phase, phase_next;
  logic                   nibble_high, nibble_high_next;
  logic [BYTE_W-1:0]      assembled, assembled_next;
  logic [LENGTH_W-1:0]    length_value, length_value_next;
  logic [LENGTH_W-1:0]    byte_count, byte_count_next;
  logic [BYTE_W-1:0]      running_sum, running_sum_next;
  logic [TIMER_WIDTH-1:0] wait_count, wait_count_next;
  logic [RETRY_W-1:0]     retry_count, retry_count_next;
  logic [LINES_W-1:0]     prev_sample;
  logic [LINES_W-1:0]     drive, drive_next;

  logic                   out_valid;
  logic                   bvalid, blast;
  logic [BYTE_W-1:0]      bval;
  frame_event_t           ev;

  logic                   take;
  logic [LINES_W-1:0]     s;
  logic                   got;
  logic [BYTE_W-1:0]      b;
  logic [LENGTH_W-1:0]    length_hi;
  logic [TIMER_WIDTH-1:0] wait_inc;
  logic [TIMER_WIDTH-1:0] timeout_cmp;

  assign status.ready = !out_valid || result.ready;
  assign take         = status.valid && status.ready;
  assign s            = status.status_lines;

  assign timeout_cmp = TIMER_WIDTH'(nibble_timeout);
  assign wait_inc    = wait_count + TIMER_WIDTH'(1);
  assign got         = (s == prev_sample) && (s[STROBE_BIT] == nibble_high);
  assign b           = assembled | {s[NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
  assign length_hi   = {b, length_value[BYTE_W-1:0]};

  always_comb begin
    phase_next        = phase;
    nibble_high_next  = nibble_high;
    assembled_next    = assembled;
    length_value_next = length_value;
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    wait_count_next   = wait_count;
    retry_count_next  = retry_count;
    drive_next        = drive;
    bvalid            = 1'b0;
    bval              = '0;
    blast             = 1'b0;
    ev                = EV_NONE;

    unique case (phase)
      PH_RECOVER: begin
        if (s == PAT_RECOVER) phase_next = PH_IDLE;
      end
      PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_SUM: begin
        if (!got) begin
          wait_count_next = wait_inc;
          if (wait_inc == timeout_cmp) begin
            wait_count_next = '0;
            if (retry_count >= max_retries) ev = EV_TIMEOUT;
            else retry_count_next = retry_count + RETRY_W'(1);
          end
        end else if (!nibble_high) begin
          wait_count_next  = '0;
          assembled_next   = {{NIBBLE_W{1'b0}}, s[NIBBLE_W-1:0]};
          drive_next       = DRV_LOW_ACK;
          nibble_high_next = 1'b1;
        end else begin
          wait_count_next  = '0;
          assembled_next   = b;
          drive_next       = DRV_HIGH_ACK;
          nibble_high_next = 1'b0;
          unique case (phase)
            PH_LEN_LO: begin
              length_value_next = {{(LENGTH_W-BYTE_W){1'b0}}, b};
              phase_next        = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              length_value_next = length_hi;
              if (length_hi > max_length || length_hi < MIN_LENGTH) begin
                ev = EV_LENGTH;
              end else begin
                byte_count_next  = '0;
                running_sum_next = '0;
                phase_next       = PH_DATA;
              end
            end
            PH_DATA: begin
              running_sum_next = running_sum + b;
              byte_count_next  = byte_count + LENGTH_W'(1);
              bvalid           = 1'b1;
              bval             = b;
              if (byte_count_next == length_value) begin
                blast      = 1'b1;
                phase_next = PH_SUM;
              end
            end
            default: begin
              // checksum byte
              if (b != running_sum) begin
                ev = EV_CHECKSUM;
              end else begin
                ev         = EV_GOOD;
                drive_next = DRV_IDLE;
                phase_next = PH_IDLE;
              end
            end
          endcase
        end
        if (ev == EV_CHECKSUM || ev == EV_LENGTH || ev == EV_TIMEOUT) begin
          drive_next = DRV_IDLE;
          phase_next = PH_RECOVER;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (s == PAT_START) begin
          drive_next        = DRV_START;
          phase_next        = PH_LEN_LO;
          nibble_high_next  = 1'b0;
          retry_count_next  = '0;
          wait_count_next   = '0;
          length_value_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_timeout <= NIBBLE_TIMEOUT_RESET;
      max_length     <= MAX_LENGTH_RESET;
      max_retries    <= MAX_RETRIES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NIBBLE_TIMEOUT: nibble_timeout <= cfg_data;
        CFG_MAX_LENGTH:     max_length     <= cfg_data;
        CFG_MAX_RETRIES:    max_retries    <= cfg_data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      nibble_high  <= 1'b0;
      assembled    <= '0;
      length_value <= '0;
      byte_count   <= '0;
      running_sum  <= '0;
      wait_count   <= '0;
      retry_count  <= '0;
      prev_sample  <= '0;
      drive        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        nibble_high  <= nibble_high_next;
        assembled    <= assembled_next;
        length_value <= length_value_next;
        byte_count   <= byte_count_next;
        running_sum  <= running_sum_next;
        wait_count   <= wait_count_next;
        retry_count  <= retry_count_next;
        prev_sample  <= s;
        drive        <= drive_next;
        out_valid    <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (take) begin
      result.drive_lines  <= drive_next;
      result.byte_valid   <= bvalid;
      result.byte_value   <= bval;
      result.byte_last    <= blast;
      result.frame_event  <= ev;
      result.frame_length <= (ev != EV_NONE) ? length_value_next : '0;
      result.link_busy    <= (phase_next != PH_IDLE);
    end
  end

  assign result.valid = out_valid;

  a_error_recovers: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.frame_event == EV_CHECKSUM || result.frame_event == EV_LENGTH ||
                  result.frame_event == EV_TIMEOUT)
    |-> phase == PH_RECOVER && result.drive_lines == DRV_IDLE)
    else $error("error event without recovery");

  a_good_idles: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.frame_event == EV_GOOD |-> phase == PH_IDLE && !result.link_busy)
    else $error("good frame did not return to idle");

  a_byte_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.byte_valid |-> phase == PH_DATA || phase == PH_SUM)
    else $error("data byte outside data phase");

  a_start: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_IDLE && s == PAT_START
    |=> phase == PH_LEN_LO && result.drive_lines == DRV_START)
    else $error("start pattern not answered");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> $stable(phase) && $stable(wait_count))
    else $error("state moved while result stalled");

endmodule

`default_nettype wire
